@@ rtl/evr_pkg.sv @@
// package: payload types and constants for the euler vector rotation block
`timescale 1ns / 1ps
package evr_pkg;

  localparam int TURN_UNITS    = 23040;
  localparam int QUARTER_UNITS = 5760;
  localparam int MAX_STEPS     = 24;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] angle_first;
    logic signed [15:0] angle_second;
    logic signed [15:0] angle_third;
  } evr_in_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } evr_out_t;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic logic signed [24:0] atan_deg(input int i);
    logic signed [24:0] v;
    case (i)
      0: v = 25'sd2949120;  1: v = 25'sd1740967;  2: v = 25'sd919879;
      3: v = 25'sd466945;   4: v = 25'sd234379;   5: v = 25'sd117304;
      6: v = 25'sd58666;    7: v = 25'sd29335;    8: v = 25'sd14668;
      9: v = 25'sd7334;     10: v = 25'sd3667;    11: v = 25'sd1833;
      12: v = 25'sd917;     13: v = 25'sd458;     14: v = 25'sd229;
      15: v = 25'sd115;     16: v = 25'sd57;      17: v = 25'sd29;
      18: v = 25'sd14;      19: v = 25'sd7;       20: v = 25'sd4;
      21: v = 25'sd2;       22: v = 25'sd1;       default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/evr_cordic.sv @@
// pipelined sin/cos cordic: one register stage per iteration plus quadrant fix
`timescale 1ns / 1ps
module evr_cordic import evr_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [15:0]          angle,
  output logic signed [FRAC_BITS+1:0] cos_o,
  output logic signed [FRAC_BITS+1:0] sin_o
);

  localparam int NS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

  // stage 0: angle reduction to residue and quadrant
  logic [14:0]        r_c;
  logic [1:0]         q_c;
  logic [12:0]        t_c;
  logic signed [16:0] m_c;

  always_comb begin
    // fold into one turn with compares against the turn size
    if (angle < -16'(TURN_UNITS)) m_c = 17'(angle) + 17'(2*TURN_UNITS);
    else if (angle < 16'sd0) m_c = 17'(angle) + 17'(TURN_UNITS);
    else if (angle >= 16'(TURN_UNITS)) m_c = 17'(angle) - 17'(TURN_UNITS);
    else m_c = 17'(angle);
    r_c = m_c[14:0];
    if (r_c >= 15'(3*QUARTER_UNITS)) begin
      q_c = 2'd3; t_c = 13'(r_c - 15'(3*QUARTER_UNITS));
    end else if (r_c >= 15'(2*QUARTER_UNITS)) begin
      q_c = 2'd2; t_c = 13'(r_c - 15'(2*QUARTER_UNITS));
    end else if (r_c >= 15'(QUARTER_UNITS)) begin
      q_c = 2'd1; t_c = 13'(r_c - 15'(QUARTER_UNITS));
    end else begin
      q_c = 2'd0; t_c = r_c[12:0];
    end
  end

  logic signed [33:0] x_r [NS+1];
  logic signed [33:0] y_r [NS+1];
  logic signed [25:0] z_r [NS+1];
  logic [1:0]         q_r [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= 26'(signed'({1'b0, t_c}) * 26'sd1024);
      q_r[0] <= q_c;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - 26'(atan_deg(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + 26'(atan_deg(i));
        end
      end
    end
  end

  // round q4.30 to nearest at FRAC_BITS fraction bits and apply the quadrant
  localparam int SH = 30 - FRAC_BITS;
  logic signed [34:0] cx, sy;
  logic signed [FRAC_BITS+1:0] c_c, s_c;
  always_comb begin
    cx = (35'(x_r[NS]) + (35'sd1 <<< (SH - 1))) >>> SH;
    sy = (35'(y_r[NS]) + (35'sd1 <<< (SH - 1))) >>> SH;
    c_c = cx[FRAC_BITS+1:0];
    s_c = sy[FRAC_BITS+1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[NS])
        2'd0: begin cos_o <= c_c;  sin_o <= s_c;  end
        2'd1: begin cos_o <= -s_c; sin_o <= c_c;  end
        2'd2: begin cos_o <= -c_c; sin_o <= -s_c; end
        default: begin cos_o <= s_c; sin_o <= -c_c; end
      endcase
    end
  end

endmodule

@@ rtl/evr_plane.sv @@
// one plane rotation: product stage, then sum and rounding stage
`timescale 1ns / 1ps
module evr_plane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+1:0] c,
  input  logic signed [FRAC_BITS+1:0] s,
  input  logic signed [33:0]          a,
  input  logic signed [33:0]          b,
  output logic signed [33:0]          a_o,
  output logic signed [33:0]          b_o
);

  // a' = c*a - s*b, b' = s*a + c*b
  localparam int PW = 36 + FRAC_BITS;
  logic signed [PW-1:0] ca_r, sb_r, sa_r, cb_r;
  logic signed [PW+1:0] ra, rb;

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r <= PW'(c * a);
      sb_r <= PW'(s * b);
      sa_r <= PW'(s * a);
      cb_r <= PW'(c * b);
    end
  end

  always_comb begin
    ra = ((PW+2)'(ca_r) - (PW+2)'(sb_r) + ((PW+2)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rb = ((PW+2)'(sa_r) + (PW+2)'(cb_r) + ((PW+2)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_o <= ra[33:0];
      b_o <= rb[33:0];
    end
  end

endmodule

@@ rtl/euler_vector_rotation.sv @@
// top level: three cordic sin/cos pipelines feeding three chained plane rotations
`timescale 1ns / 1ps
//
//  channel | ports                       | dir | role
//  in      | in_valid, in_stall, in_data | in  | vector and three angles
//  out     | out_valid, out_stall, out_data | out | rotated, saturated vector
//
//  one beat accepted per cycle unless the output is stalled; a beat passes the
//  cordic stages, each rotation's product and sum stages and the output register
//  the whole pipeline advances together; out_stall with out_valid set freezes
//  it, and in_stall is high while frozen, so nothing is lost or repeated
//  rst_n (synchronous) clears only the valid bits
//
module euler_vector_rotation import evr_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  evr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output evr_out_t out_data
);

  localparam int NS   = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int CLAT = NS + 2;       // cordic latency
  localparam int LAT  = NS + 9;       // total latency
  localparam int FW   = FRAC_BITS + 2;

  // pipeline moves when the output slot is free
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [LAT-1:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[LAT-2:0], in_valid};
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= vld_nxt;
  end
  assign out_valid = vld_r[LAT-1];

  // sin/cos for all three angles in parallel
  logic signed [FW-1:0] c1, s1, c2, s2, c3, s3;
  evr_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cor1 (
    .clk, .en, .angle(in_data.angle_first),  .cos_o(c1), .sin_o(s1));
  evr_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cor2 (
    .clk, .en, .angle(in_data.angle_second), .cos_o(c2), .sin_o(s2));
  evr_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cor3 (
    .clk, .en, .angle(in_data.angle_third),  .cos_o(c3), .sin_o(s3));

  // vector delay line matching cordic latency
  logic signed [31:0] vx_r [CLAT], vy_r [CLAT], vz_r [CLAT];
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= in_data.vec_x;
      vy_r[0] <= in_data.vec_y;
      vz_r[0] <= in_data.vec_z;
      for (int k = 1; k < CLAT; k++) begin
        vx_r[k] <= vx_r[k-1];
        vy_r[k] <= vy_r[k-1];
        vz_r[k] <= vz_r[k-1];
      end
    end
  end

  // sin/cos delays for the later rotations
  logic signed [FW-1:0] c2_r [2], s2_r [2], c3_r [4], s3_r [4];
  logic signed [33:0]   z1_r [2];
  logic signed [33:0]   x1, y1, x2, z2, y3, z3;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r[0] <= c2; c2_r[1] <= c2_r[0];
      s2_r[0] <= s2; s2_r[1] <= s2_r[0];
      c3_r[0] <= c3; s3_r[0] <= s3;
      for (int k = 1; k < 4; k++) begin
        c3_r[k] <= c3_r[k-1];
        s3_r[k] <= s3_r[k-1];
      end
      z1_r[0] <= 34'(vz_r[CLAT-1]); z1_r[1] <= z1_r[0];
    end
  end

  // x-y plane
  evr_plane #(.FRAC_BITS(FRAC_BITS)) u_rot1 (
    .clk, .en, .c(c1), .s(s1),
    .a(34'(vx_r[CLAT-1])), .b(34'(vy_r[CLAT-1])), .a_o(x1), .b_o(y1));

  // x-z plane: x' = c*x + s*z, z' = c*z - s*x, i.e. (z,x) rotated by s
  evr_plane #(.FRAC_BITS(FRAC_BITS)) u_rot2 (
    .clk, .en, .c(c2_r[1]), .s(s2_r[1]),
    .a(z1_r[1]), .b(x1), .a_o(z2), .b_o(x2));

  // y-z plane; y comes from rotation one, delayed two stages
  logic signed [33:0] y1_r [2];
  always_ff @(posedge clk) begin
    if (en) begin
      y1_r[0] <= y1;
      y1_r[1] <= y1_r[0];
    end
  end
  evr_plane #(.FRAC_BITS(FRAC_BITS)) u_rot3 (
    .clk, .en, .c(c3_r[3]), .s(s3_r[3]),
    .a(y1_r[1]), .b(z2), .a_o(y3), .b_o(z3));

  // x from rotation two delayed to line up with rotation three
  logic signed [33:0] x3_r [2];
  always_ff @(posedge clk) begin
    if (en) begin
      x3_r[0] <= x2;
      x3_r[1] <= x3_r[0];
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.rot_x <= sat32(x3_r[1]);
      out_data.rot_y <= sat32(y3);
      out_data.rot_z <= sat32(z3);
    end
  end

endmodule

@@ test/tb_top.sv @@
// testbench: checks the euler vector rotation block against its own fixed-point predictor
`timescale 1ns / 1ps
module tb_top;
  import evr_pkg::*;

  localparam int STEPS   = 16;
  localparam int FRAC    = 16;
  localparam int LATENCY = STEPS + 9;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  evr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  evr_out_t out_data;

  // predicted rotated vectors, oldest first
  evr_out_t rotated_q[$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       beats_seen = 0;
  int       stall_mode = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  euler_vector_rotation #(.CORDIC_STEPS(STEPS), .FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // arctangent of 2^-i, degrees scaled by 2^16
  function automatic longint arctan_step(int i);
    longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  // cosine and sine of an angle in 1/64 degree, at FRAC fraction bits
  function automatic void trig_of(input logic signed [15:0] ang, output longint c,
                                  output longint s);
    longint r, q, t, x, y, z, nx, cr, sr;
    r = longint'(ang) % 23040;
    if (r < 0) r += 23040;
    q = r / 5760;
    t = r - q * 5760;
    x = 652032874;
    y = 0;
    z = t * 1024;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      // >>> on longint floors, matching arithmetic shift
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    cr = (x + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    sr = (y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    case (q)
      0: begin c = cr;  s = sr;  end
      1: begin c = -sr; s = cr;  end
      2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endfunction

  function automatic longint rescale(longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic evr_out_t rotate_vector(evr_in_t b);
    longint x, y, z, c, s, a, e;
    evr_out_t r;
    x = b.vec_x; y = b.vec_y; z = b.vec_z;
    trig_of(b.angle_first, c, s);
    a = rescale(c * x - s * y);
    e = rescale(s * x + c * y);
    x = a; y = e;
    trig_of(b.angle_second, c, s);
    a = rescale(c * x + s * z);
    e = rescale(c * z - s * x);
    x = a; z = e;
    trig_of(b.angle_third, c, s);
    a = rescale(c * y - s * z);
    e = rescale(s * y + c * z);
    y = a; z = e;
    r.rot_x = clamp32(x);
    r.rot_y = clamp32(y);
    r.rot_z = clamp32(z);
    return r;
  endfunction

  // send one beat; valid stays high across back-to-back beats
  task automatic send_beat(input evr_in_t b, input bit keep_valid);
    in_data  <= b;
    in_valid <= 1'b1;
    rotated_q.insert(rotated_q.size(), rotate_vector(b));
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
    if (!keep_valid) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic idle_gap(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    while (rotated_q.size() != 0) @(negedge clk);
  endtask

  function automatic evr_in_t random_beat(bit wide_angles);
    evr_in_t b;
    b.vec_x = $urandom;
    b.vec_y = $urandom;
    b.vec_z = $urandom;
    // small vectors half the time so results are not always saturated
    if ($urandom_range(1, 0)) begin
      b.vec_x = $signed(b.vec_x) >>> $urandom_range(31, 8);
      b.vec_y = $signed(b.vec_y) >>> $urandom_range(31, 8);
      b.vec_z = $signed(b.vec_z) >>> $urandom_range(31, 8);
    end
    b.angle_first  = 16'($urandom);
    b.angle_second = 16'($urandom);
    b.angle_third  = 16'($urandom);
    if (!wide_angles) begin
      b.angle_first  = 16'($urandom_range(23039, 0));
      b.angle_second = 16'($urandom_range(23039, 0));
      b.angle_third  = 16'($urandom_range(23039, 0));
    end
    return b;
  endfunction

  // check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (rotated_q.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatches++;
      end else begin
        evr_out_t e;
        e = rotated_q.pop_front();
        if (out_data.rot_x !== e.rot_x) begin
          $error("rot_x expected %0d actual %0d", e.rot_x, out_data.rot_x);
          mismatches++;
        end
        if (out_data.rot_y !== e.rot_y) begin
          $error("rot_y expected %0d actual %0d", e.rot_y, out_data.rot_y);
          mismatches++;
        end
        if (out_data.rot_z !== e.rot_z) begin
          $error("rot_z expected %0d actual %0d", e.rot_z, out_data.rot_z);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern: none, sparse, heavy, periodic
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(9, 0) == 0);
      2: out_stall <= ($urandom_range(2, 0) != 0);
      default: out_stall <= ((stall_phase % 7) < 3);
    endcase
  end

  // directed corners: zero angles, quadrant edges, full turns, extremes, saturation
  task automatic test_directed();
    evr_in_t b;
    logic signed [15:0] angs [12] = '{16'sd0, 16'sd5760, 16'sd11520, 16'sd17280,
      16'sd23040, -16'sd5760, 16'sd5759, 16'sd2880, 16'sh7fff, 16'sh8000,
      -16'sd1, -16'sd23040};
    for (int i = 0; i < 12; i++) begin
      b.vec_x = 32'sh00010000; b.vec_y = 32'sh00020000; b.vec_z = -32'sh00030000;
      b.angle_first = angs[i]; b.angle_second = angs[(i + 3) % 12];
      b.angle_third = angs[(i + 7) % 12];
      send_beat(b, i[0]);
    end
    // extreme components, forcing both clamps
    b = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sd2880, 16'sd2880, 16'sd2880};
    send_beat(b, 1'b0);
    b = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sd2880, -16'sd2880, 16'sd2880};
    send_beat(b, 1'b0);
    b = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_beat(b, 1'b1);
    b = '{32'sh0, 32'sh0, 32'sh0, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_beat(b, 1'b0);
    b = '{-32'sd1, 32'sd1, -32'sd1, 16'sd0, 16'sd0, 16'sd0};
    send_beat(b, 1'b0);
    drain();
  endtask

  // bursts of random beats with random gaps, under a given stall pattern
  task automatic test_random_bursts(int mode, int count, bit wide_angles);
    int left;
    int burst;
    stall_mode = mode;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(12, 1);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) send_beat(random_beat(wide_angles), k != burst - 1);
      left -= burst;
      if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(LATENCY + 3, 1));
    end
  endtask

  // the sender holds off until every prediction has been met
  task automatic test_hold_off_drain();
    stall_mode = 1;
    for (int k = 0; k < 20; k++) send_beat(random_beat(1'b1), 1'b1);
    send_beat(random_beat(1'b0), 1'b0);
    drain();
    for (int k = 0; k < 10; k++) send_beat(random_beat(1'b1), k != 9);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_bursts(0, 300, 1'b1);
    test_random_bursts(1, 300, 1'b0);
    test_hold_off_drain();
    test_random_bursts(2, 250, 1'b1);
    test_random_bursts(3, 250, 1'b1);
    drain();
    stall_mode = 0;
    repeat (LATENCY + 5) @(negedge clk);
    $display("sent %0d beats (corners, random bursts, four stall patterns, one drain pause)",
             beats_sent);
    $display("checked %0d result beats", beats_seen);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout after %0d beats sent", beats_sent);
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/evr_pkg.sv
rtl/evr_cordic.sv
rtl/evr_plane.sv
rtl/euler_vector_rotation.sv
test/tb_top.sv
